/* rtl/bcmp_pkg.sv */
// bcmp_pkg: shared types, constants and status codes of the binomial coefficient block
// depends on nothing
package bcmp_pkg;

   localparam int unsigned TABLE_TOP_DEFAULT = 4095;
   localparam int unsigned VAL_W = 30;
   localparam int unsigned ARG_W = 16;
   localparam logic [VAL_W-1:0] MOD_PRIME = 30'd1000000007;
   localparam logic [VAL_W-1:0] FERMAT_EXP = 30'd1000000005;
   localparam longint unsigned BARRETT_M_FULL = (64'd1 << 60) / 64'd1000000007;
   localparam logic [30:0] BARRETT_M = 31'(BARRETT_M_FULL);
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned OUT_DEPTH = 16;
   localparam int unsigned MM_LAT = 4;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_K_OVER_N = 2'd1;
   localparam logic [1:0] STATUS_N_OVER_TOP = 2'd2;

   typedef struct packed {
      logic [ARG_W-1:0] n_total;
      logic [ARG_W-1:0] k_choose;
   } req_type;

   typedef struct packed {
      logic [VAL_W-1:0] coefficient;
      logic [1:0]       status;
   } rsp_type;

   typedef struct packed {
      logic [ARG_W-1:0] n_idx;
      logic [ARG_W-1:0] k_idx;
      logic [ARG_W-1:0] nk_idx;
      logic [1:0]       status;
   } query_type;

endpackage

/* rtl/binomial_coefficient_mod_prime.sv */
// binomial_coefficient_mod_prime: top level, n choose k modulo 1000000007
// depends on bcmp_pkg, bcmp_init, bcmp_front, bcmp_back
//
// After reset the block builds its factorial and inverse factorial tables before it takes
// any item, using the single four stage modular multiplier of the table builder for the
// factorials, a square-and-multiply for the inverse of TABLE_TOP factorial, and the
// inverse factorials. Then it accepts one query item per cycle while its input queue has
// room; each result passes through a table read, two four stage modular multipliers and the
// result buffer, and up to 16 results may wait in the output buffer.
// n beyond TABLE_TOP answers 0 with status 2, k greater than n answers 0 with status 1.
module binomial_coefficient_mod_prime import bcmp_pkg::*; #(
   parameter int unsigned TABLE_TOP = TABLE_TOP_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int unsigned IDX_W = $clog2(TABLE_TOP + 1);

   logic fact_we, inv_we, init_done;
   logic [IDX_W-1:0] wr_addr;
   logic [VAL_W-1:0] wr_data;
   logic q_valid, q_pop;
   query_type q_data;

   bcmp_init #(.TABLE_TOP(TABLE_TOP)) u_init (
      .clock     (clock),
      .reset     (reset),
      .fact_we   (fact_we),
      .inv_we    (inv_we),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .init_done (init_done)
   );

   bcmp_front #(.TABLE_TOP(TABLE_TOP)) u_front (
      .clock     (clock),
      .reset     (reset),
      .init_done (init_done),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_pop     (q_pop)
   );

   bcmp_back #(.TABLE_TOP(TABLE_TOP)) u_back (
      .clock     (clock),
      .reset     (reset),
      .fact_we   (fact_we),
      .inv_we    (inv_we),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

/* rtl/bcmp_ram.sv */
// bcmp_ram: generic single write, single read ram with registered read data
// depends on nothing
module bcmp_ram #(
   parameter int unsigned WIDTH = 30,
   parameter int unsigned DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

/* rtl/bcmp_modmul.sv */
// bcmp_modmul: four stage multiplier modulo the prime, barrett reduction
// depends on bcmp_pkg
module bcmp_modmul import bcmp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [VAL_W-1:0] a,
   input  logic [VAL_W-1:0] b,
   output logic             out_valid,
   output logic [VAL_W-1:0] p
);

   logic [MM_LAT-1:0] valid_ff;
   logic [59:0] prod_ff;
   logic [61:0] est_ff;
   logic [31:0] low_ff;
   logic [31:0] rem_ff;
   logic [VAL_W-1:0] p_ff;
   logic [30:0] quot;
   logic [31:0] qp_low;
   logic [31:0] mod1;
   logic [31:0] mod2;

   assign quot = est_ff[61:31];
   assign qp_low = 32'(32'(quot) * 32'(MOD_PRIME));
   assign mod1 = 32'(MOD_PRIME);
   assign mod2 = 32'(MOD_PRIME) << 1;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[MM_LAT-2:0], in_valid};
      end
      prod_ff <= 60'(a) * 60'(b);
      est_ff <= 62'(prod_ff[59:29]) * 62'(BARRETT_M);
      low_ff <= prod_ff[31:0];
      rem_ff <= low_ff - qp_low;
      if (rem_ff >= mod2) begin
         p_ff <= VAL_W'(rem_ff - mod2);
      end else if (rem_ff >= mod1) begin
         p_ff <= VAL_W'(rem_ff - mod1);
      end else begin
         p_ff <= VAL_W'(rem_ff);
      end
   end

   assign out_valid = valid_ff[MM_LAT-1];
   assign p = p_ff;

endmodule

/* rtl/bcmp_init.sv */
// bcmp_init: builds the factorial and inverse factorial tables after reset
// depends on bcmp_pkg, bcmp_modmul
module bcmp_init import bcmp_pkg::*; #(
   parameter int unsigned TABLE_TOP = TABLE_TOP_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   output logic                                fact_we,
   output logic                                inv_we,
   output logic [$clog2(TABLE_TOP+1)-1:0]      wr_addr,
   output logic [VAL_W-1:0]                    wr_data,
   output logic                                init_done
);

   localparam int unsigned IDX_W = $clog2(TABLE_TOP + 1);
   localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(TABLE_TOP);

   localparam logic [3:0] ST_F0     = 4'd0;
   localparam logic [3:0] ST_FMUL   = 4'd1;
   localparam logic [3:0] ST_FWAIT  = 4'd2;
   localparam logic [3:0] ST_PSTEP  = 4'd3;
   localparam logic [3:0] ST_PMWAIT = 4'd4;
   localparam logic [3:0] ST_PSQ    = 4'd5;
   localparam logic [3:0] ST_PSWAIT = 4'd6;
   localparam logic [3:0] ST_IWR    = 4'd7;
   localparam logic [3:0] ST_IMUL   = 4'd8;
   localparam logic [3:0] ST_IWAIT  = 4'd9;
   localparam logic [3:0] ST_DONE   = 4'd10;

   logic [3:0] state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [VAL_W-1:0] acc_ff, acc_in;
   logic [VAL_W-1:0] base_ff, base_in;
   logic [VAL_W-1:0] exp_ff, exp_in;
   logic mm_valid;
   logic [VAL_W-1:0] mm_a;
   logic [VAL_W-1:0] mm_b;
   logic mm_out_valid;
   logic [VAL_W-1:0] mm_p;

   bcmp_modmul u_modmul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mm_valid),
      .a         (mm_a),
      .b         (mm_b),
      .out_valid (mm_out_valid),
      .p         (mm_p)
   );

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      acc_in = acc_ff;
      base_in = base_ff;
      exp_in = exp_ff;
      mm_valid = 1'b0;
      mm_a = acc_ff;
      mm_b = VAL_W'(idx_ff);
      fact_we = 1'b0;
      inv_we = 1'b0;
      wr_addr = idx_ff;
      wr_data = mm_p;
      case (state_ff)
         ST_F0: begin
            fact_we = 1'b1;
            wr_addr = '0;
            wr_data = VAL_W'(1);
            acc_in = VAL_W'(1);
            idx_in = IDX_W'(1);
            state_in = ST_FMUL;
         end
         ST_FMUL: begin
            mm_valid = 1'b1;
            state_in = ST_FWAIT;
         end
         ST_FWAIT: begin
            if (mm_out_valid) begin
               fact_we = 1'b1;
               acc_in = mm_p;
               if (idx_ff == TOP_IDX) begin
                  base_in = mm_p;
                  acc_in = VAL_W'(1);
                  exp_in = FERMAT_EXP;
                  state_in = ST_PSTEP;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
                  state_in = ST_FMUL;
               end
            end
         end
         ST_PSTEP: begin
            mm_b = base_ff;
            if (exp_ff == '0) begin
               state_in = ST_IWR;
            end else if (exp_ff[0]) begin
               mm_valid = 1'b1;
               state_in = ST_PMWAIT;
            end else begin
               mm_a = base_ff;
               mm_valid = 1'b1;
               state_in = ST_PSWAIT;
            end
         end
         ST_PMWAIT: begin
            if (mm_out_valid) begin
               acc_in = mm_p;
               state_in = ST_PSQ;
            end
         end
         ST_PSQ: begin
            mm_a = base_ff;
            mm_b = base_ff;
            mm_valid = 1'b1;
            state_in = ST_PSWAIT;
         end
         ST_PSWAIT: begin
            if (mm_out_valid) begin
               base_in = mm_p;
               exp_in = exp_ff >> 1;
               state_in = ST_PSTEP;
            end
         end
         ST_IWR: begin
            inv_we = 1'b1;
            wr_addr = TOP_IDX;
            wr_data = acc_ff;
            idx_in = TOP_IDX;
            state_in = ST_IMUL;
         end
         ST_IMUL: begin
            mm_valid = 1'b1;
            state_in = ST_IWAIT;
         end
         ST_IWAIT: begin
            wr_addr = idx_ff - IDX_W'(1);
            if (mm_out_valid) begin
               inv_we = 1'b1;
               acc_in = mm_p;
               idx_in = idx_ff - IDX_W'(1);
               if (idx_ff == IDX_W'(1)) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_IMUL;
               end
            end
         end
         ST_DONE: begin
            state_in = ST_DONE;
         end
         default: begin
            state_in = ST_F0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_F0;
      end else begin
         state_ff <= state_in;
      end
      idx_ff <= idx_in;
      acc_ff <= acc_in;
      base_ff <= base_in;
      exp_ff <= exp_in;
   end

   assign init_done = (state_ff == ST_DONE);

endmodule

/* rtl/bcmp_front.sv */
// bcmp_front: accepts query items, classifies them and queues them for the back end
// depends on bcmp_pkg
module bcmp_front import bcmp_pkg::*; #(
   parameter int unsigned TABLE_TOP = TABLE_TOP_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      init_done,
   input  logic      req_valid,
   output logic      req_ready,
   input  req_type   req_data,
   output logic      q_valid,
   output query_type q_data,
   input  logic      q_pop
);

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   query_type mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   query_type entry;
   logic push;

   always_comb begin
      entry = '0;
      if (32'(req_data.n_total) > 32'(TABLE_TOP)) begin
         entry.status = STATUS_N_OVER_TOP;
      end else if (req_data.k_choose > req_data.n_total) begin
         entry.status = STATUS_K_OVER_N;
      end else begin
         entry.status = STATUS_OK;
         entry.n_idx = req_data.n_total;
         entry.k_idx = req_data.k_choose;
         entry.nk_idx = req_data.n_total - req_data.k_choose;
      end
   end

   assign req_ready = init_done && (count_ff < CNT_W'(QUEUE_DEPTH));
   assign push = req_valid && req_ready;
   assign q_valid = (count_ff != '0);
   assign q_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in = count_ff + CNT_W'(push) - CNT_W'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

/* rtl/bcmp_back.sv */
// bcmp_back: table reads, two modular multiplications and the result buffer
// depends on bcmp_pkg, bcmp_ram, bcmp_modmul
module bcmp_back import bcmp_pkg::*; #(
   parameter int unsigned TABLE_TOP = TABLE_TOP_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           fact_we,
   input  logic                           inv_we,
   input  logic [$clog2(TABLE_TOP+1)-1:0] wr_addr,
   input  logic [VAL_W-1:0]               wr_data,
   input  logic                           q_valid,
   input  query_type                      q_data,
   output logic                           q_pop,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output rsp_type                        rsp_data
);

   localparam int unsigned DEPTH = TABLE_TOP + 1;
   localparam int unsigned IDX_W = $clog2(DEPTH);
   localparam int unsigned PTR_W = $clog2(OUT_DEPTH);
   localparam int unsigned CNT_W = $clog2(OUT_DEPTH + 1);
   localparam int unsigned ST_DLY = 2 * MM_LAT;

   logic [VAL_W-1:0] fact_rd, invk_rd, invnk_rd;
   logic rd_valid_ff;
   logic [1:0] status_ff;
   logic [VAL_W-1:0] nk_dly_ff [MM_LAT];
   logic [1:0] st_dly_ff [ST_DLY];
   logic mm1_valid, mm2_valid;
   logic [VAL_W-1:0] mm1_p, mm2_p;
   rsp_type out_mem_ff [OUT_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] credit_ff, credit_in;
   logic take;
   rsp_type result;

   bcmp_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_fact (
      .clock (clock), .we (fact_we), .waddr (wr_addr), .wdata (wr_data),
      .raddr (IDX_W'(q_data.n_idx)), .rdata (fact_rd)
   );

   bcmp_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_inv_k (
      .clock (clock), .we (inv_we), .waddr (wr_addr), .wdata (wr_data),
      .raddr (IDX_W'(q_data.k_idx)), .rdata (invk_rd)
   );

   bcmp_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_inv_nk (
      .clock (clock), .we (inv_we), .waddr (wr_addr), .wdata (wr_data),
      .raddr (IDX_W'(q_data.nk_idx)), .rdata (invnk_rd)
   );

   bcmp_modmul u_mm1 (
      .clock (clock), .reset (reset), .in_valid (rd_valid_ff),
      .a (fact_rd), .b (invk_rd), .out_valid (mm1_valid), .p (mm1_p)
   );

   bcmp_modmul u_mm2 (
      .clock (clock), .reset (reset), .in_valid (mm1_valid),
      .a (mm1_p), .b (nk_dly_ff[MM_LAT-1]), .out_valid (mm2_valid), .p (mm2_p)
   );

   assign q_pop = q_valid && (credit_ff < CNT_W'(OUT_DEPTH));
   assign take = rsp_valid && rsp_ready;
   assign rsp_valid = (fill_ff != '0);
   assign rsp_data = out_mem_ff[rd_ptr_ff];

   always_comb begin
      result.status = st_dly_ff[ST_DLY-1];
      result.coefficient = (st_dly_ff[ST_DLY-1] == STATUS_OK) ? mm2_p : '0;
      fill_in = fill_ff + CNT_W'(mm2_valid) - CNT_W'(take);
      credit_in = credit_ff + CNT_W'(q_pop) - CNT_W'(take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff <= '0;
         credit_ff <= '0;
      end else begin
         rd_valid_ff <= q_pop;
         if (mm2_valid) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (take) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         fill_ff <= fill_in;
         credit_ff <= credit_in;
      end
      status_ff <= q_data.status;
      nk_dly_ff[0] <= invnk_rd;
      for (int i = 1; i < MM_LAT; i++) begin
         nk_dly_ff[i] <= nk_dly_ff[i-1];
      end
      st_dly_ff[0] <= status_ff;
      for (int i = 1; i < ST_DLY; i++) begin
         st_dly_ff[i] <= st_dly_ff[i-1];
      end
      if (mm2_valid) begin
         out_mem_ff[wr_ptr_ff] <= result;
      end
   end

endmodule

/* sim/testbench.sv */
// testbench: self-checking bench for binomial_coefficient_mod_prime (n choose k mod 1000000007)
// depends on bcmp_pkg and the rtl top level; predicts most results from its own factorial tables
`timescale 1ns / 100ps

module testbench;
   import bcmp_pkg::*;

   localparam int unsigned TOP = TABLE_TOP_DEFAULT;
   localparam longint unsigned PRIME = 64'd1000000007;
   localparam int N_RANDOM = 930;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   rsp_type expected_rsp_q[$];
   longint unsigned fact_tbl[TOP+1];
   longint unsigned inv_fact_tbl[TOP+1];
   int error_count = 0;
   int result_count = 0;
   int status_seen[3] = '{0, 0, 0};
   bit rsp_idle_enable = 1'b0;
   bit rsp_hold = 1'b0;

   typedef struct {
      logic [ARG_W-1:0] n;
      logic [ARG_W-1:0] k;
      bit               known;
      rsp_type          rsp;
   } stim_row_type;

   binomial_coefficient_mod_prime u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint unsigned mul_mod(longint unsigned a, longint unsigned b);
      return (a * b) % PRIME;
   endfunction

   function automatic rsp_type binomial_predict(logic [ARG_W-1:0] n, logic [ARG_W-1:0] k);
      rsp_type r;
      r = '0;
      if (n > TOP) begin
         r.status = STATUS_N_OVER_TOP;
      end else if (k > n) begin
         r.status = STATUS_K_OVER_N;
      end else begin
         r.coefficient = VAL_W'(mul_mod(mul_mod(fact_tbl[n], inv_fact_tbl[k]),
                                        inv_fact_tbl[n-k]));
         r.status = STATUS_OK;
      end
      return r;
   endfunction

   task automatic build_tables();
      longint unsigned acc, base, e;
      fact_tbl[0] = 1;
      for (int i = 1; i <= TOP; i++) fact_tbl[i] = mul_mod(fact_tbl[i-1], i);
      acc = 1;
      base = fact_tbl[TOP];
      e = PRIME - 2;
      while (e != 0) begin
         if (e[0]) acc = mul_mod(acc, base);
         base = mul_mod(base, base);
         e = e >> 1;
      end
      inv_fact_tbl[TOP] = acc;
      for (int i = TOP; i > 0; i--) inv_fact_tbl[i-1] = mul_mod(inv_fact_tbl[i], i);
   endtask

   task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
      $display("mismatch %0s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   task automatic send_query(logic [ARG_W-1:0] n, logic [ARG_W-1:0] k, bit idle_on,
                             bit known = 1'b0, rsp_type want = '0);
      if (idle_on) begin
         while ($urandom_range(99) < 6) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= '{n_total: n, k_choose: k};
      expected_rsp_q.push_back(known ? want : binomial_predict(n, k));
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_rsp_q.size() != 0);
   endtask

   function automatic logic [ARG_W-1:0] pick_n();
      int sel;
      sel = $urandom_range(99);
      if (sel < 80) return ARG_W'($urandom_range(TOP));
      if (sel < 88) return ARG_W'($urandom_range(TOP, TOP - 3));
      return ARG_W'($urandom_range(65535, TOP + 1));
   endfunction

   // response side
   always @(posedge clock) begin
      if (rsp_valid && rsp_ready) begin
         if (expected_rsp_q.size() == 0) begin
            report_mismatch("unexpected item", rsp_data, 0);
         end else begin
            rsp_type want;
            want = expected_rsp_q.pop_front();
            if (rsp_data.coefficient !== want.coefficient)
               report_mismatch("coefficient", rsp_data.coefficient, want.coefficient);
            if (rsp_data.status !== want.status)
               report_mismatch("status", rsp_data.status, want.status);
            if (want.status <= 2) status_seen[want.status]++;
            result_count++;
         end
      end
      if (reset || rsp_hold)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= !(rsp_idle_enable && $urandom_range(99) < 6);
   end

   initial begin
      #(20_000_000);
      $display("FAILURE");
      $finish;
   end

   initial begin
      stim_row_type rows[$];
      logic [ARG_W-1:0] n, k;
      build_tables();
      rows.push_back('{0, 0, 1, '{1, STATUS_OK}});
      rows.push_back('{1, 0, 1, '{1, STATUS_OK}});
      rows.push_back('{1, 1, 1, '{1, STATUS_OK}});
      rows.push_back('{TOP, 0, 1, '{1, STATUS_OK}});
      rows.push_back('{TOP, TOP, 1, '{1, STATUS_OK}});
      rows.push_back('{TOP, 1, 1, '{TOP, STATUS_OK}});
      rows.push_back('{5, 2, 1, '{10, STATUS_OK}});
      rows.push_back('{0, 1, 1, '{0, STATUS_K_OVER_N}});
      rows.push_back('{0, 16'hFFFF, 1, '{0, STATUS_K_OVER_N}});
      rows.push_back('{TOP, TOP + 1, 1, '{0, STATUS_K_OVER_N}});
      rows.push_back('{TOP + 1, 0, 1, '{0, STATUS_N_OVER_TOP}});
      rows.push_back('{16'hFFFF, 16'hFFFF, 1, '{0, STATUS_N_OVER_TOP}});
      rows.push_back('{16'hFFFF, 0, 1, '{0, STATUS_N_OVER_TOP}});
      rows.push_back('{16'h8000, 16'h7FFF, 1, '{0, STATUS_N_OVER_TOP}});
      rows.push_back('{TOP, TOP / 2, 0, '0});
      rows.push_back('{TOP, 16'h0AAA, 0, '0});
      rows.push_back('{16'h0555, 16'h0555 >> 1, 0, '0});
      rows.push_back('{100, 50, 0, '0});
      rows.push_back('{2048, 1024, 0, '0});

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i]) send_query(rows[i].n, rows[i].k, 1'b0, rows[i].known, rows[i].rsp);
      wait_drained();

      // long back-pressure stretch while the sender keeps offering items
      fork
         begin
            rsp_hold = 1'b1;
            repeat (200) @(posedge clock);
            rsp_hold = 1'b0;
         end
         for (int i = 0; i < 40; i++) begin
            n = ARG_W'($urandom_range(TOP));
            send_query(n, ARG_W'($urandom_range(n)), 1'b0);
         end
      join
      wait_drained();

      // no idling on either side
      for (int i = 0; i < 150; i++) begin
         n = pick_n();
         k = ($urandom_range(9) == 0) ? ARG_W'($urandom) : ARG_W'($urandom_range(n));
         send_query(n, k, 1'b0);
      end
      wait_drained();

      rsp_idle_enable = 1'b1;
      for (int i = 0; i < N_RANDOM - 190; i++) begin
         n = pick_n();
         case ($urandom_range(9))
            0: k = ARG_W'($urandom);
            1: k = n + ARG_W'($urandom_range(3, 1));
            2: k = n;
            default: k = ARG_W'($urandom_range(n));
         endcase
         send_query(n, k, 1'b1);
      end
      wait_drained();
      repeat (30) @(posedge clock);

      $display("covered %0d results: %0d ok, %0d k over n, %0d n over table top",
               result_count, status_seen[0], status_seen[1], status_seen[2]);
      if (error_count == 0 && expected_rsp_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
